// ===== rtl/cmap_pkg.sv =====
package cmap_pkg;

	localparam int WINDOW = 16;
	localparam int SAMPLE_W = 16;
	localparam int TIME_W = 32;
	localparam int POS_W = 10;
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int TOTAL_W = SAMPLE_W + $clog2(WINDOW + 1);
	localparam int MAP_W = 27;
	localparam int DIVD_W = (TOTAL_W > MAP_W) ? TOTAL_W : MAP_W;
	localparam int DIVS_W = SAMPLE_W + 1;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
	localparam int MAP_SCALE = 2046;

	localparam logic [SAMPLE_W-1:0] CAP_MIN_RST = 16'd0;
	localparam logic [SAMPLE_W-1:0] CAP_MAX_RST = 16'hFFFF;
	localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd1000;

	typedef enum logic [1:0] {
		REG_CAP_MIN = 2'd0,
		REG_CAP_MAX = 2'd1,
		REG_INTERVAL = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_UPDATE,
		ST_AVG,
		ST_MAP,
		ST_MUL,
		ST_MAP_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_ms;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic updated;
	} out_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] cap_min;
		logic [SAMPLE_W-1:0] cap_max;
		logic [TIME_W-1:0] interval_ms;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/cmap_regs.sv =====
module cmap_regs
	import cmap_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cap_min <= CAP_MIN_RST;
			cfg_q.cap_max <= CAP_MAX_RST;
			cfg_q.interval_ms <= INTERVAL_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CAP_MIN: cfg_q.cap_min <= pwdata[SAMPLE_W-1:0];
				REG_CAP_MAX: cfg_q.cap_max <= pwdata[SAMPLE_W-1:0];
				REG_INTERVAL: cfg_q.interval_ms <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CAP_MIN: prdata = DATA_W'(cfg_q.cap_min);
			REG_CAP_MAX: prdata = DATA_W'(cfg_q.cap_max);
			REG_INTERVAL: prdata = DATA_W'(cfg_q.interval_ms);
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/cmap_ring.sv =====
module cmap_ring
	import cmap_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [SLOT_W-1:0] rd_addr,
	output logic [SAMPLE_W-1:0] rd_data,
	input logic wr_en,
	input logic [SLOT_W-1:0] wr_addr,
	input logic [SAMPLE_W-1:0] wr_data
);

	logic [SAMPLE_W-1:0] mem [WINDOW];
	logic [WINDOW-1:0] vld_q;
	logic [SAMPLE_W-1:0] rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/cmap_div.sv =====
module cmap_div
	import cmap_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIVD_W);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIVS_W:0] trial;
	logic [DIVS_W:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff = trial - {1'b0, div_q};
	assign ge = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/clamped_moving_average_position.sv =====
// channel   word        handshake                    direction
// item      in_item_t   item_valid / item_stall      in
// result    out_item_t  result_valid / result_stall  out
// config    APB         psel / penable / pready      in (write), prdata out
//
// A skipped item goes from CHECK to EMIT; the next item is taken once EMIT has passed its
// result to the output register. A measurement runs CHECK, UPDATE, AVG, MAP, MUL and MAP_WAIT,
// where the one-bit-per-cycle divider maps the average, then EMIT; MAP goes to EMIT at once
// when the span is empty or the average reaches cap_max. One item is in work at a time.
// Reset clears the total, slot, timestamps and the ring's valid bits (unwritten entries read 0).
// The output register holds a result under result_stall while the block takes the next item.
module clamped_moving_average_position
	import cmap_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output out_item_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg;
	state_t state_q, state_d;
	div_req_t div_req;
	div_rsp_t div_rsp;

	in_item_t item_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [DIVD_W-1:0] product_q;
	logic [POS_W-1:0] pos_q;
	logic upd_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] last_time_q;
	logic [POS_W-1:0] last_pos_q;
	logic result_valid_q;
	out_item_t result_q;

	logic accept;
	logic skip;
	logic emit_fire;
	logic [SAMPLE_W-1:0] clamped;
	logic [SAMPLE_W-1:0] lo_clamped;
	logic [SAMPLE_W-1:0] rd_data;
	logic rd_en;
	logic wr_en;
	logic empty_span;
	logic num_pos;
	logic [SAMPLE_W-1:0] num;
	logic [SAMPLE_W-1:0] den;

	cmap_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	cmap_ring u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(slot_q),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(slot_q),
		.wr_data(sample_q)
	);

	cmap_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign skip = (item_q.time_ms - last_time_q) < cfg.interval_ms;
	assign lo_clamped = (item_q.sample < cfg.cap_min) ? cfg.cap_min : item_q.sample;
	assign clamped = (lo_clamped > cfg.cap_max) ? cfg.cap_max : lo_clamped;
	assign empty_span = cfg.cap_max <= cfg.cap_min;
	assign num_pos = cfg.cap_max > avg_q;
	assign num = cfg.cap_max - avg_q;
	assign den = cfg.cap_max - cfg.cap_min;
	assign emit_fire = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_CHECK;
			ST_CHECK: state_d = skip ? ST_EMIT : ST_UPDATE;
			ST_UPDATE: state_d = ST_AVG;
			ST_AVG: state_d = ST_MAP;
			ST_MAP: state_d = (empty_span || !num_pos) ? ST_EMIT : ST_MUL;
			ST_MUL: state_d = ST_MAP_WAIT;
			ST_MAP_WAIT: if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT: if (emit_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = product_q + DIVD_W'(den);
		div_req.divisor = {den, 1'b0};
		unique case (state_q)
			ST_CHECK: rd_en = !skip;
			ST_UPDATE: wr_en = 1'b1;
			ST_MUL: div_req.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			slot_q <= '0;
			last_time_q <= '0;
			last_pos_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK && !skip) begin
				last_time_q <= item_q.time_ms;
			end
			if (state_q == ST_UPDATE) begin
				total_q <= total_q - TOTAL_W'(rd_data) + TOTAL_W'(sample_q);
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
			if (emit_fire) begin
				last_pos_q <= pos_q;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		unique case (state_q)
			ST_CHECK: begin
				sample_q <= clamped;
				pos_q <= last_pos_q;
				upd_q <= !skip;
			end
			ST_AVG: avg_q <= SAMPLE_W'(total_q / TOTAL_W'(WINDOW));
			ST_MAP: begin
				product_q <= DIVD_W'(num) * DIVD_W'(MAP_SCALE);
				if (empty_span) begin
					pos_q <= (avg_q < cfg.cap_min) ? POS_MAX : '0;
				end else begin
					pos_q <= '0;
				end
			end
			ST_MAP_WAIT: begin
				if (div_rsp.done) begin
					pos_q <= (div_rsp.quotient > DIVD_W'(POS_MAX)) ? POS_MAX
						: div_rsp.quotient[POS_W-1:0];
				end
			end
			default: ;
		endcase
		if (emit_fire) begin
			result_q.position <= pos_q;
			result_q.updated <= upd_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
